>>> rtl/perspective_grid_line_generator_macros.svh
`ifndef PERSPECTIVE_GRID_LINE_GENERATOR_MACROS_SVH
`define PERSPECTIVE_GRID_LINE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define PGLG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pglg: same-cycle check failed");

// Next-cycle implication.
`define PGLG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pglg: next-cycle check failed");

`endif

>>> rtl/pglg_pkg.sv
`default_nettype none
package pglg_pkg;

    localparam int HORIZ_COUNT_DEF = 20;
    localparam int VERT_REACH_DEF  = 10;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [63:0] wide_t;
    typedef logic signed [31:0] coord_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPACING = 3'd0,
        REG_FOCAL   = 3'd1,
        REG_CAM     = 3'd2,
        REG_HORIZON = 3'd3,
        REG_HALF    = 3'd4,
        REG_CENTER  = 3'd5,
        REG_FAR     = 3'd6,
        REG_ROWS    = 3'd7
    } cfg_idx_t;

    localparam logic [13:0] SPACING_RST = 14'd5120;
    localparam logic [9:0]  FOCAL_RST   = 10'd200;
    localparam logic [7:0]  CAM_RST     = 8'd10;
    localparam logic [9:0]  HORIZON_RST = 10'd120;
    localparam logic [9:0]  HALF_RST    = 10'd200;
    localparam logic [10:0] CENTER_RST  = 11'd160;
    localparam logic [15:0] FAR_RST     = 16'd51200;
    localparam logic [10:0] ROWS_RST    = 11'd240;

    // Depth 1.0 in Q8.8.
    localparam logic signed [20:0] DEPTH_ONE = 21'sd256;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_CH,
        ST_P_HW,
        ST_P_RX,
        ST_P_Y1,
        ST_W_Y1,
        ST_H_TEST,
        ST_W_SY,
        ST_W_W,
        ST_H_EMIT,
        ST_H_NEXT,
        ST_V_MUL,
        ST_V_X1,
        ST_W_X1,
        ST_V_PMUL,
        ST_V_PDIV,
        ST_W_CLIP,
        ST_V_EMIT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic long_mode;
    } div_req_t;

    function automatic logic [23:0] sat24(input wide_t v);
        logic [23:0] r;
        if (v > 64'sd8388607)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -64'sd8388608)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/pglg_div.sv
`default_nettype none
// Signed divider, one quotient bit per cycle, truncating toward zero.
// Short mode takes a dividend that fits 32 bits and runs 32 steps; long mode runs 64.
module pglg_div (
    input  wire                    clk,
    input  wire                    rst_n,
    input  pglg_pkg::div_req_t     req,
    input  pglg_pkg::wide_t        dividend,
    input  pglg_pkg::coord_t       divisor,
    output logic                   done,
    output pglg_pkg::wide_t        quotient
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;

    logic [63:0] mag;
    logic [32:0] rem_sh;
    logic        fits;

    assign mag    = dividend[63] ? 64'(-dividend) : 64'(dividend);
    assign rem_sh = {rem_reg, q_reg[63]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start && !run_reg)
        begin
            run_next = 1'b1;
            rem_next = '0;
            dvs_next = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next = dividend[63] ^ divisor[31];
            if (req.long_mode)
            begin
                q_next   = mag;
                cnt_next = 7'd64;
            end
            else
            begin
                q_next   = {mag[31:0], 32'd0};
                cnt_next = 7'd32;
            end
        end
        else if (run_reg)
        begin
            rem_next = fits ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
            q_next   = {q_reg[62:0], fits};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

>>> rtl/perspective_grid_line_generator.sv
`default_nettype none
// Perspective grid line generator. An advance item (tuser 0) moves the scroll offset and
// is taken with no result. A draw item (tuser 1) produces the frame's segment list:
// surviving horizontal lines near-to-far in order of index, then 2*VERT_REACH+1 vertical
// lines, the last one flagged with tlast. All work runs through one shared 32x32
// multiplier and one shared divider that retires one quotient bit per cycle. After its
// setup a draw culls each horizontal line that is nearer than depth 1.0 or lies below
// the screen, and clips the near point of a vertical line that lies below the screen
// with an extra long division; stalls on the output side lengthen the draw. s_tready
// is low for the whole draw.
module perspective_grid_line_generator #(
    parameter int HORIZ_COUNT = pglg_pkg::HORIZ_COUNT_DEF,
    parameter int VERT_REACH  = pglg_pkg::VERT_REACH_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [15:0]                     s_tdata,   // speed_q8[15:0]
    input  wire  [0:0]                      s_tuser,   // req_type[0]
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [95:0]                     m_tdata,   // x_start, y_start, x_end, y_end
    output logic [0:0]                      m_tuser,   // line_kind[0]
    output logic                            m_tlast,
    input  wire                             cfg_we,
    input  wire  [pglg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire  [pglg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HI_W   = $clog2(HORIZ_COUNT + 1);
    localparam int VI_W   = $clog2(2 * VERT_REACH + 2);
    localparam logic [HI_W-1:0] HI_LAST = HI_W'(HORIZ_COUNT - 1);
    localparam logic [VI_W-1:0] VI_LAST = VI_W'(2 * VERT_REACH);

    // Configuration registers.
    logic [13:0] spacing_reg;
    logic [9:0]  focal_reg;
    logic [7:0]  cam_reg;
    logic [9:0]  horizon_reg;
    logic [9:0]  half_reg;
    logic [10:0] center_reg;
    logic [15:0] far_reg;
    logic [10:0] rows_reg;
    logic [13:0] scroll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= pglg_pkg::SPACING_RST;
            focal_reg   <= pglg_pkg::FOCAL_RST;
            cam_reg     <= pglg_pkg::CAM_RST;
            horizon_reg <= pglg_pkg::HORIZON_RST;
            half_reg    <= pglg_pkg::HALF_RST;
            center_reg  <= pglg_pkg::CENTER_RST;
            far_reg     <= pglg_pkg::FAR_RST;
            rows_reg    <= pglg_pkg::ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (pglg_pkg::cfg_idx_t'(cfg_addr))
                pglg_pkg::REG_SPACING: spacing_reg <= cfg_wdata[13:0];
                pglg_pkg::REG_FOCAL:   focal_reg   <= cfg_wdata[9:0];
                pglg_pkg::REG_CAM:     cam_reg     <= cfg_wdata[7:0];
                pglg_pkg::REG_HORIZON: horizon_reg <= cfg_wdata[9:0];
                pglg_pkg::REG_HALF:    half_reg    <= cfg_wdata[9:0];
                pglg_pkg::REG_CENTER:  center_reg  <= cfg_wdata[10:0];
                pglg_pkg::REG_FAR:     far_reg     <= cfg_wdata[15:0];
                pglg_pkg::REG_ROWS:    rows_reg    <= cfg_wdata[10:0];
                default:               spacing_reg <= spacing_reg;
            endcase
        end
    end

    pglg_pkg::seq_state_t state_reg, state_next;

    logic in_acc;
    assign s_tready = (state_reg == pglg_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Advance: clamp, add, wrap once.
    logic [13:0] speed_clamped;
    logic [14:0] scroll_sum;
    logic [14:0] scroll_wrap;
    assign speed_clamped = (s_tdata > {2'b00, spacing_reg}) ? spacing_reg : s_tdata[13:0];
    assign scroll_sum    = {1'b0, scroll_reg} + {1'b0, speed_clamped};
    assign scroll_wrap   = (scroll_sum >= {1'b0, spacing_reg}) ?
                           (scroll_sum - {1'b0, spacing_reg}) : scroll_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_reg <= '0;
        end
        else if (in_acc && !s_tuser[0])
        begin
            scroll_reg <= scroll_wrap[13:0];
        end
    end

    // Shared multiplier and divider.
    pglg_pkg::coord_t   mul_a, mul_b;
    pglg_pkg::wide_t    mul_reg;
    pglg_pkg::div_req_t div_req;
    pglg_pkg::wide_t    div_dividend;
    pglg_pkg::coord_t   div_divisor;
    logic               div_done;
    pglg_pkg::wide_t    div_q;

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    pglg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Datapath registers.
    logic [17:0]             ch_reg;
    logic [19:0]             hw_reg;
    logic signed [20:0]      zacc_reg;
    logic signed [19:0]      xacc_reg;
    pglg_pkg::coord_t        y1_reg;
    pglg_pkg::coord_t        sy_reg;
    pglg_pkg::coord_t        w_reg;
    pglg_pkg::wide_t         x0_reg;
    pglg_pkg::coord_t        x1_reg;
    pglg_pkg::coord_t        yv0_reg;
    logic [HI_W-1:0]         hi_reg;
    logic [VI_W-1:0]         vi_reg;

    pglg_pkg::coord_t rows_s, horizon_s, center_s, y0_s, far_s, z_s;
    pglg_pkg::coord_t sy_now, x1_now;
    pglg_pkg::wide_t  ch_sh, hw_sh, x0_adj;
    logic             out_free, emit, emit_kind, emit_last;

    assign rows_s    = pglg_pkg::coord_t'({21'd0, rows_reg});
    assign horizon_s = pglg_pkg::coord_t'({22'd0, horizon_reg});
    assign center_s  = pglg_pkg::coord_t'({21'd0, center_reg});
    assign y0_s      = pglg_pkg::coord_t'({14'd0, ch_reg}) + horizon_s;
    assign far_s     = (far_reg == 16'd0) ? 32'sd1 : pglg_pkg::coord_t'({16'd0, far_reg});
    assign z_s       = pglg_pkg::coord_t'(zacc_reg);
    assign ch_sh     = pglg_pkg::wide_t'({38'd0, ch_reg, 8'd0});
    assign hw_sh     = pglg_pkg::wide_t'({36'd0, hw_reg, 8'd0});
    assign sy_now    = pglg_pkg::coord_t'(div_q[31:0]) + horizon_s;
    assign x1_now    = pglg_pkg::coord_t'(div_q[31:0]) + center_s;
    // x*focal/256 truncated toward zero: bias negative values before the shift.
    assign x0_adj    = (mul_reg + (mul_reg[63] ? 64'sd255 : 64'sd0)) >>> 8;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pglg_pkg::ST_IDLE:   if (in_acc && s_tuser[0]) state_next = pglg_pkg::ST_P_CH;
            pglg_pkg::ST_P_CH:   state_next = pglg_pkg::ST_P_HW;
            pglg_pkg::ST_P_HW:   state_next = pglg_pkg::ST_P_RX;
            pglg_pkg::ST_P_RX:   state_next = pglg_pkg::ST_P_Y1;
            pglg_pkg::ST_P_Y1:   state_next = pglg_pkg::ST_W_Y1;
            pglg_pkg::ST_W_Y1:   if (div_done) state_next = pglg_pkg::ST_H_TEST;
            pglg_pkg::ST_H_TEST:
            begin
                if (zacc_reg < pglg_pkg::DEPTH_ONE)
                    state_next = pglg_pkg::ST_H_NEXT;
                else
                    state_next = pglg_pkg::ST_W_SY;
            end
            pglg_pkg::ST_W_SY:
            begin
                if (div_done)
                    state_next = (sy_now >= rows_s) ? pglg_pkg::ST_H_NEXT : pglg_pkg::ST_W_W;
            end
            pglg_pkg::ST_W_W:    if (div_done) state_next = pglg_pkg::ST_H_EMIT;
            pglg_pkg::ST_H_EMIT: if (out_free) state_next = pglg_pkg::ST_H_NEXT;
            pglg_pkg::ST_H_NEXT:
            begin
                state_next = (hi_reg == HI_LAST) ? pglg_pkg::ST_V_MUL : pglg_pkg::ST_H_TEST;
            end
            pglg_pkg::ST_V_MUL:  state_next = pglg_pkg::ST_V_X1;
            pglg_pkg::ST_V_X1:   state_next = pglg_pkg::ST_W_X1;
            pglg_pkg::ST_W_X1:
            begin
                if (div_done)
                begin
                    if (y0_s >= rows_s && y0_s != y1_reg)
                        state_next = pglg_pkg::ST_V_PMUL;
                    else
                        state_next = pglg_pkg::ST_V_EMIT;
                end
            end
            pglg_pkg::ST_V_PMUL: state_next = pglg_pkg::ST_V_PDIV;
            pglg_pkg::ST_V_PDIV: state_next = pglg_pkg::ST_W_CLIP;
            pglg_pkg::ST_W_CLIP: if (div_done) state_next = pglg_pkg::ST_V_EMIT;
            pglg_pkg::ST_V_EMIT:
            begin
                if (out_free)
                    state_next = (vi_reg == VI_LAST) ? pglg_pkg::ST_IDLE : pglg_pkg::ST_V_MUL;
            end
            default:             state_next = pglg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        div_dividend = ch_sh;
        div_divisor  = far_s;
        emit         = 1'b0;
        emit_kind    = 1'b0;
        emit_last    = 1'b0;
        case (state_reg)
            pglg_pkg::ST_P_CH:
            begin
                mul_a = pglg_pkg::coord_t'({24'd0, cam_reg});
                mul_b = pglg_pkg::coord_t'({22'd0, focal_reg});
            end
            pglg_pkg::ST_P_HW:
            begin
                mul_a = pglg_pkg::coord_t'({22'd0, half_reg});
                mul_b = pglg_pkg::coord_t'({22'd0, focal_reg});
            end
            pglg_pkg::ST_P_RX:
            begin
                mul_a = pglg_pkg::coord_t'(VERT_REACH);
                mul_b = pglg_pkg::coord_t'({18'd0, spacing_reg});
            end
            pglg_pkg::ST_P_Y1:
            begin
                div_req.start = 1'b1;
            end
            pglg_pkg::ST_H_TEST:
            begin
                div_req.start = (zacc_reg >= pglg_pkg::DEPTH_ONE);
                div_divisor   = z_s;
            end
            pglg_pkg::ST_W_SY:
            begin
                div_req.start = div_done && (sy_now < rows_s);
                div_dividend  = hw_sh;
                div_divisor   = z_s;
            end
            pglg_pkg::ST_H_EMIT:
            begin
                emit = out_free;
            end
            pglg_pkg::ST_V_MUL:
            begin
                mul_a = pglg_pkg::coord_t'(xacc_reg);
                mul_b = pglg_pkg::coord_t'({22'd0, focal_reg});
            end
            pglg_pkg::ST_V_X1:
            begin
                div_req.start = 1'b1;
                div_dividend  = mul_reg;
            end
            pglg_pkg::ST_V_PMUL:
            begin
                mul_a = pglg_pkg::coord_t'(x0_reg[31:0]) - x1_reg;
                mul_b = rows_s - 32'sd1 - y1_reg;
            end
            pglg_pkg::ST_V_PDIV:
            begin
                div_req.start     = 1'b1;
                div_req.long_mode = 1'b1;
                div_dividend      = mul_reg;
                div_divisor       = y0_s - y1_reg;
            end
            pglg_pkg::ST_V_EMIT:
            begin
                emit      = out_free;
                emit_kind = 1'b1;
                emit_last = (vi_reg == VI_LAST);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pglg_pkg::ST_IDLE;
            hi_reg    <= '0;
            vi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pglg_pkg::ST_IDLE)
            begin
                hi_reg <= '0;
                vi_reg <= '0;
            end
            if (state_reg == pglg_pkg::ST_H_NEXT)
            begin
                hi_reg <= hi_reg + HI_W'(1);
            end
            if (state_reg == pglg_pkg::ST_V_EMIT && out_free)
            begin
                vi_reg <= vi_reg + VI_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pglg_pkg::ST_P_HW: ch_reg <= mul_reg[17:0];
            pglg_pkg::ST_P_RX: hw_reg <= mul_reg[19:0];
            pglg_pkg::ST_P_Y1: xacc_reg <= -mul_reg[19:0];
            pglg_pkg::ST_W_Y1:
            begin
                y1_reg   <= pglg_pkg::coord_t'(div_q[31:0]) + horizon_s;
                zacc_reg <= $signed({7'd0, spacing_reg}) - $signed({7'd0, scroll_reg});
            end
            pglg_pkg::ST_W_SY: if (div_done) sy_reg <= sy_now;
            pglg_pkg::ST_W_W:  if (div_done) w_reg <= pglg_pkg::coord_t'(div_q[31:0]);
            pglg_pkg::ST_H_NEXT: zacc_reg <= zacc_reg + $signed({7'd0, spacing_reg});
            pglg_pkg::ST_V_X1: x0_reg <= x0_adj + pglg_pkg::wide_t'(center_s);
            pglg_pkg::ST_W_X1:
            begin
                if (div_done)
                begin
                    x1_reg  <= x1_now;
                    yv0_reg <= (y0_s >= rows_s) ? (rows_s - 32'sd1) : y0_s;
                end
            end
            pglg_pkg::ST_W_CLIP:
            begin
                if (div_done) x0_reg <= pglg_pkg::wide_t'(x1_reg) + div_q;
            end
            pglg_pkg::ST_V_EMIT:
            begin
                if (out_free) xacc_reg <= xacc_reg + $signed({6'd0, spacing_reg});
            end
            default: w_reg <= w_reg;
        endcase
    end

    // Output register.
    logic        out_valid_reg;
    logic [23:0] xs_reg, ys_reg, xe_reg, ye_reg;
    logic        kind_reg, last_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= emit_kind;
            last_reg <= emit_last;
            if (emit_kind)
            begin
                xs_reg <= pglg_pkg::sat24(x0_reg);
                ys_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(yv0_reg));
                xe_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(x1_reg));
                ye_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(y1_reg));
            end
            else
            begin
                xs_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(center_s - w_reg));
                ys_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(sy_reg));
                xe_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(center_s + w_reg));
                ye_reg <= pglg_pkg::sat24(pglg_pkg::wide_t'(sy_reg));
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {ye_reg, xe_reg, ys_reg, xs_reg};
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

endmodule
`default_nettype wire

>>> rtl/pglg_checker.sv
`default_nettype none
`include "perspective_grid_line_generator_macros.svh"
module pglg_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [0:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        m_tlast
);

    // A stalled item keeps its payload.
    `PGLG_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Mid-frame the block is busy drawing.
    `PGLG_ASSERT_IMP(a_busy_mid_frame, m_tvalid && !m_tlast, !s_tready)

    // A draw item starts a busy period; an advance item does not.
    `PGLG_ASSERT_NXT(a_draw_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)
    `PGLG_ASSERT_NXT(a_advance_free, s_tvalid && s_tready && !s_tuser[0], s_tready)

    // The frame always ends on a vertical line.
    `PGLG_ASSERT_IMP(a_last_vertical, m_tvalid && m_tlast, m_tuser[0])

endmodule

bind perspective_grid_line_generator pglg_checker u_pglg_checker (.*);
`default_nettype wire
